// ===== rtl/spif_pkg.sv =====
// ----------------------------------------------------------------------------
// spif_pkg
// Shared types and constants of the sorted packed identifier filter table.
// ----------------------------------------------------------------------------
package spif_pkg;

    localparam int KIND_W  = 1;
    localparam int IDENT_W = 11;
    localparam int WIDX_W  = 9;
    localparam int CTRL_W  = 3;
    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int COUNT_W = 10;
    localparam int GSTART_W = 11;
    localparam int TEND_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL_FIELD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_WORD = 1'b1;

    localparam logic [CTRL_W-1:0] CTRL_FIELD_RST = 3'd1;
    localparam logic [WORD_W-1:0] GROUP_WORD_RST = 32'd2047;

    localparam logic [HALF_W-1:0] ENTRY_MASK = 16'hF7FF;
    localparam logic [HALF_W-1:0] HALF_PAD   = 16'hFFFF;

    typedef struct packed {
        logic              ins;
        logic [HALF_W-1:0] carry;
    } t_shift_st;

    typedef struct packed {
        t_shift_st         st;
        logic [HALF_W-1:0] half;
    } t_half_res;

endpackage

// ===== rtl/spif_channels.sv =====
// ----------------------------------------------------------------------------
// spif channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface spif_in_if;
    logic                          valid;
    logic                          ready;
    logic [spif_pkg::KIND_W-1:0]   kind;
    logic [spif_pkg::IDENT_W-1:0]  identifier;
    logic [spif_pkg::WIDX_W-1:0]   word_index;

    modport source (output valid, output kind, output identifier, output word_index,
                    input ready);
    modport sink   (input valid, input kind, input identifier, input word_index,
                    output ready);
endinterface

interface spif_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [spif_pkg::COUNT_W-1:0]   entry_count;
    logic [spif_pkg::GSTART_W-1:0]  group_start;
    logic [spif_pkg::TEND_W-1:0]    table_end;
    logic [spif_pkg::WORD_W-1:0]    read_word;

    modport source (output valid, output accepted, output entry_count,
                    output group_start, output table_end, output read_word, input ready);
    modport sink   (input valid, input accepted, input entry_count,
                    input group_start, input table_end, input read_word, output ready);
endinterface

interface spif_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spif_pkg::CFG_IDX_W-1:0]  index;
    logic [spif_pkg::WORD_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/spif_shift_unit.sv =====
// ----------------------------------------------------------------------------
// spif_shift_unit
// Merges the new entry into one table word and carries the displaced half.
// ----------------------------------------------------------------------------
module spif_shift_unit #(
    parameter int TABLE_WORDS = 512
) (
    input  logic [spif_pkg::WORD_W-1:0]           i_rd_word,
    input  logic [$clog2(TABLE_WORDS)-1:0]        i_word,
    input  logic [$clog2(TABLE_WORDS):0]          i_count,
    input  logic [spif_pkg::HALF_W-1:0]           i_entry,
    input  spif_pkg::t_shift_st                   i_st,
    output logic [spif_pkg::WORD_W-1:0]           o_wr_word,
    output spif_pkg::t_shift_st                   o_st
);
    import spif_pkg::*;

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int CW = AW + 1;

    function automatic t_half_res step_half(logic [CW-1:0] k, logic [HALF_W-1:0] h,
                                            logic [CW-1:0] cnt, logic [HALF_W-1:0] e,
                                            t_shift_st st);
        t_half_res r;
        r.st   = st;
        r.half = HALF_PAD;
        if (k < cnt) begin
            if (!st.ins && (h > e)) begin
                r.half     = e;
                r.st.ins   = 1'b1;
                r.st.carry = h;
            end else if (st.ins) begin
                r.half     = st.carry;
                r.st.carry = h;
            end else begin
                r.half = h;
            end
        end else if (k == cnt) begin
            r.half = st.ins ? st.carry : e;
        end
        return r;
    endfunction

    t_half_res hi_res;
    t_half_res lo_res;

    always_comb begin
        hi_res = step_half({i_word, 1'b0}, i_rd_word[WORD_W-1:HALF_W], i_count, i_entry,
                           i_st);
        lo_res = step_half({i_word, 1'b1}, i_rd_word[HALF_W-1:0], i_count, i_entry,
                           hi_res.st);
    end

    assign o_wr_word = {hi_res.half, lo_res.half};
    assign o_st      = lo_res.st;

endmodule

// ===== rtl/sorted_packed_id_filter_insert_core.sv =====
// ----------------------------------------------------------------------------
// sorted_packed_id_filter_insert_core
// Ascending filter table, two entries per word, with sorted insert and read.
//
//   channel  | dir | beat contents
//   ---------+-----+-------------------------------------------------------
//   i_in     | in  | kind, identifier, word_index
//   o_out    | out | accepted, entry_count, group_start, table_end, read_word
//   i_cfg    | in  | index, data (controller field, group range word)
//
// Insert: accept, a read and a write per table word up to the word of the new
// last entry, a group word write and a result; the single-port table (one
// read, one write per word) sets this. Read: accept, read, capture, result. A
// refused insert or out-of-range read goes from accept to result. One item at
// a time; i_in.ready is high only in idle. Results hold until o_out.ready.
// Reset clears state and count, presets config; table words are not reset.
// ----------------------------------------------------------------------------
module sorted_packed_id_filter_insert_core #(
    parameter int TABLE_WORDS = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spif_in_if.sink          i_in,
    spif_out_if.source       o_out,
    spif_cfg_if.sink         i_cfg
);
    import spif_pkg::*;

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int CW = AW + 1;
    localparam int XW = (CW > WIDX_W) ? CW : WIDX_W;
    localparam int OW = (CW + 3 > TEND_W) ? CW + 3 : TEND_W;
    localparam logic [CW-1:0] TW_C      = CW'(TABLE_WORDS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(2 * TABLE_WORDS - 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SWR  = 3'd2;
    localparam logic [2:0] S_GRP  = 3'd3;
    localparam logic [2:0] S_QRD  = 3'd4;
    localparam logic [2:0] S_QCAP = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CTRL_W-1:0]   r_ctrl_field;
    logic [WORD_W-1:0]   r_group_word;

    logic [AW-1:0]       r_word, n_word;
    logic [HALF_W-1:0]   r_entry, n_entry;
    t_shift_st           r_st, n_st;
    logic                r_acc, n_acc;
    logic [WORD_W-1:0]   r_rd_word, n_rd_word;

    logic [WORD_W-1:0]   r_mem [TABLE_WORDS];
    logic [WORD_W-1:0]   r_rdata;
    logic                mem_re;
    logic                mem_we;
    logic [WORD_W-1:0]   mem_wdata;

    logic [WORD_W-1:0]   sh_wr_word;
    t_shift_st           sh_st;

    logic [CW:0]         grow_sum;
    logic                full;
    logic [CW:0]         used_sum;
    logic [CW-1:0]       used;
    logic [XW-1:0]       widx_x;
    logic                rd_ok;
    logic [OW-1:0]       gs_x;
    logic [OW-1:0]       te_x;
    logic [OW-1:0]       cnt_x;

    spif_shift_unit #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_shift (
        .i_rd_word (r_rdata),
        .i_word    (r_word),
        .i_count   (r_count),
        .i_entry   (r_entry),
        .i_st      (r_st),
        .o_wr_word (sh_wr_word),
        .o_st      (sh_st)
    );

    always_comb begin
        grow_sum = {1'b0, r_count} + (CW+1)'(2);
        full     = !(grow_sum[CW:1] < TW_C);
        used_sum = {1'b0, r_count} + (CW+1)'(1);
        used     = used_sum[CW:1];
        widx_x   = XW'(i_in.word_index);
        rd_ok    = (r_count != '0) && (widx_x <= XW'(used)) && (widx_x < XW'(TW_C));
        gs_x     = OW'(used) << 2;
        te_x     = gs_x + OW'(4);
        cnt_x    = OW'(r_count);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_word    = r_word;
        n_entry   = r_entry;
        n_st      = r_st;
        n_acc     = r_acc;
        n_rd_word = r_rd_word;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = sh_wr_word;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_acc     = 1'b0;
                    n_rd_word = '0;
                    n_st      = '0;
                    if (i_in.kind == KIND_INSERT) begin
                        n_entry = {r_ctrl_field, 2'b00, i_in.identifier} & ENTRY_MASK;
                        n_word  = '0;
                        n_state = full ? S_OUT : S_SRD;
                    end else begin
                        n_word  = widx_x[AW-1:0];
                        n_state = rd_ok ? S_QRD : S_OUT;
                    end
                end
            end
            S_SRD: begin
                mem_re  = 1'b1;
                n_state = S_SWR;
            end
            S_SWR: begin
                mem_we  = 1'b1;
                n_st    = sh_st;
                n_word  = r_word + AW'(1);
                n_state = (r_word == r_count[CW-1:1]) ? S_GRP : S_SRD;
            end
            S_GRP: begin
                mem_we    = 1'b1;
                mem_wdata = r_group_word;
                n_count   = r_count + CW'(1);
                n_acc     = 1'b1;
                n_state   = S_OUT;
            end
            S_QRD: begin
                mem_re  = 1'b1;
                n_state = S_QCAP;
            end
            S_QCAP: begin
                n_rd_word = r_rdata;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ctrl_field <= CTRL_FIELD_RST;
            r_group_word <= GROUP_WORD_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_CTRL_FIELD: r_ctrl_field <= i_cfg.data[CTRL_W-1:0];
                    REG_GROUP_WORD: r_group_word <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_entry   <= n_entry;
        r_st      <= n_st;
        r_acc     <= n_acc;
        r_rd_word <= n_rd_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_word] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_word];
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.accepted    = r_acc;
    assign o_out.entry_count = cnt_x[COUNT_W-1:0];
    assign o_out.group_start = gs_x[GSTART_W-1:0];
    assign o_out.table_end   = te_x[TEND_W-1:0];
    assign o_out.read_word   = r_rd_word;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is pending");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("entry count beyond table capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> $stable(r_count))
        else $error("entry count moved while a result is held");

    a_word_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR) |-> (r_word <= r_count[CW-1:1]))
        else $error("shift pass ran past the last used word");

    a_grp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRP) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the entry count");

endmodule
